// ===== rtl/core/epoch_to_calendar_time_top_assert.svh =====
// Assertion macros for the epoch-to-calendar converter.
// Clocked on clk; the reset-gated form is disabled while rst_n is low.
`ifndef EPOCH_TO_CALENDAR_TIME_TOP_ASSERT_SVH
`define EPOCH_TO_CALENDAR_TIME_TOP_ASSERT_SVH

`ifndef SYNTH
// checked only out of reset
`define E2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define E2C_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2C_ASSERT(lbl, prop, msg)
`define E2C_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/e2c_pkg.sv =====
// Constants, types and lookup tables for the epoch-to-calendar converter.
// No dependencies; imported by epoch_to_calendar_time_top.
`timescale 1ns / 1ps
`default_nettype none

package e2c_pkg;

  // Payload widths
  localparam int SECS_W   = 31;
  localparam int USEC_W   = 20;
  localparam int IN_DW    = 56;
  localparam int OUT_DW   = 48;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;
  localparam int OFFS_W   = 4;

  // Register map (word index)
  localparam logic CFG_IDX_UTC_OFFSET = 1'b0;
  localparam logic [OFFS_W-1:0] UTC_OFFSET_RST = 4'd8;

  // Reciprocals for constant division: q_est = (x * RECIP) >> SHIFT,
  // low by at most one, fixed by a single remainder compare.
  localparam logic [25:0] RECIP_60   = 26'd35791394;   // floor(2^31 / 60)
  localparam logic [26:0] RECIP_24   = 27'd89478485;   // floor(2^31 / 24)
  localparam logic [20:0] RECIP_1000 = 21'd1073741;    // floor(2^30 / 1000)
  localparam logic [23:0] RECIP_YEAR = 24'd11759221;   // floor(400 * 2^32 / 146097)
  localparam logic [9:0]  RECIP_30   = 10'd547;        // ceil(2^14 / 30), exact to 365

  localparam logic [24:0] CYCLE_DAYS = 25'd146097;
  localparam logic [10:0] EPOCH_YEAR = 11'd1970;
  localparam logic [9:0]  MAX_MILLI  = 10'd999;
  localparam logic [3:0]  MONTH_DEC  = 4'd11;

  // Days from 1970-01-01 to January 1 of year 1970 + i
  typedef logic [15:0] dby_tab_t [0:127];
  typedef logic [8:0]  cum_tab_t [0:15];

  function automatic dby_tab_t build_dby();
    dby_tab_t t;
    int y;
    int p;
    for (int i = 0; i < 128; i++) begin
      y = 1970 + i;
      p = y - 1;
      t[i] = 16'((y - 1970) * 365 + p / 4 - p / 100 + p / 400 - 477);
    end
    return t;
  endfunction

  // Gregorian leap flag of year 1970 + i
  function automatic logic [127:0] build_leap();
    logic [127:0] v;
    int y;
    for (int i = 0; i < 128; i++) begin
      y = 1970 + i;
      v[i] = ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
    end
    return v;
  endfunction

  localparam dby_tab_t     DBY_TAB  = build_dby();
  localparam logic [127:0] LEAP_TAB = build_leap();

  // Cumulative days before month m (0 = January), padded past December
  localparam cum_tab_t CUM_COMMON = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
                                      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365,
                                      9'd365, 9'd365, 9'd365};
  localparam cum_tab_t CUM_LEAP   = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
                                      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366,
                                      9'd366, 9'd366, 9'd366};

  function automatic logic [8:0] cum_days(logic [3:0] m, logic leap);
    return leap ? CUM_LEAP[m] : CUM_COMMON[m];
  endfunction

  // Time-of-day fields carried down the pipe
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] milli;
  } hms_t;

endpackage

`default_nettype wire

// ===== rtl/core/epoch_to_calendar_time_top.sv =====
// Epoch-to-calendar converter: Unix seconds/microseconds to local civil date and time.
// Depends on e2c_pkg and epoch_to_calendar_time_top_assert.svh.
//
//  Channel | Dir | Handshake        | Payload
//  in_     | in  | tvalid / tready  | tdata: epoch_seconds, micro_seconds
//  out_    | out | tvalid / tready  | tdata: year, month, day, hour, minute, second, milli
//  cfg_    | in  | APB, pready = 1  | utc_offset_hours at byte address 0
//
// Twelve-stage pipeline (s1 to s11, then the output register), one item per cycle unless
// the output stalls. Stages hold reciprocal multiplies, remainder corrections and lookups.
// rst_n (synchronous) empties the pipe and sets the offset to 8 hours.
// A stalled output freezes every stage; in_tready follows out_tready through
// the output register's state.
`timescale 1ns / 1ps
`default_nettype none

`include "epoch_to_calendar_time_top_assert.svh"

module epoch_to_calendar_time_top
  import e2c_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,    // epoch_seconds[30:0], micro_seconds[50:31], 0
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,   // year[10:0], month[14:11], day[19:15],
                                              // hour[24:20], minute[30:25], second[36:31],
                                              // milli[46:37], 0
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int NSTG = 12;

  logic [NSTG-1:0]   vld_r;
  logic              adv;
  logic              in_xfer;
  logic              out_xfer;
  logic [OFFS_W-1:0] utc_off_r;

  // ---------------------------------------------------------------- config
  logic cfg_wr;
  logic cfg_sel_off;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_off = (cfg_paddr[CFG_AW-1:2] == CFG_IDX_UTC_OFFSET);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = cfg_sel_off ? {{(CFG_DW-OFFS_W){1'b0}}, utc_off_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utc_off_r <= UTC_OFFSET_RST;
    end else if (cfg_wr && cfg_sel_off) begin
      utc_off_r <= cfg_pwdata[OFFS_W-1:0];
    end
  end

  // ---------------------------------------------------------------- flow
  assign adv       = !vld_r[NSTG-1] || out_tready;
  assign in_tready = adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_tvalid = vld_r[NSTG-1];
  assign out_xfer  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_xfer};
    end
  end

  // ---------------------------------------------------------------- stage registers
  logic [SECS_W-1:0] s1_secs_r, s2_secs_r;
  logic [USEC_W-1:0] s1_usec_r, s2_usec_r;
  logic [56:0]       s2_pmin_r;
  logic [40:0]       s2_pms_r;
  logic [25:0]       s3_mins_r, s4_mins_r;
  logic [51:0]       s4_phr_r;
  logic [19:0]       s5_hours_r, s6_hours_r;
  logic [46:0]       s6_pday_r;
  logic [14:0]       s7_days_r, s8_days_r, s9_days_r, s10_days_r;
  logic [38:0]       s8_pyr_r;
  logic [6:0]        s9_e_r;
  logic [6:0]        s10_k_r;
  logic [10:0]       s11_year_r;
  logic [8:0]        s11_yday_r;
  logic [3:0]        s11_q_r;
  logic              s11_leap_r;
  hms_t              s3_hms_r, s4_hms_r, s5_hms_r, s6_hms_r, s7_hms_r, s8_hms_r;
  hms_t              s9_hms_r, s10_hms_r, s11_hms_r, out_hms_r;
  logic [10:0]       out_year_r;
  logic [3:0]        out_month_r;
  logic [4:0]        out_day_r;

  // ---------------------------------------------------------------- stage 2: reciprocals
  logic [56:0] s2_pmin_nxt;
  logic [40:0] s2_pms_nxt;

  assign s2_pmin_nxt = 57'(s1_secs_r) * 57'(RECIP_60);
  assign s2_pms_nxt  = 41'(s1_usec_r) * 41'(RECIP_1000);

  // ---------------------------------------------------------------- stage 3: seconds, millis
  logic [25:0] mins_est;
  logic [31:0] mins_x60;
  logic [30:0] sec_rem;
  logic        sec_fix;
  logic [25:0] s3_mins_nxt;
  logic [10:0] ms_est;
  logic [20:0] ms_x1000;
  logic [19:0] ms_rem;
  logic [10:0] ms_q;
  hms_t        s3_hms_nxt;

  always_comb begin
    mins_est    = s2_pmin_r[56:31];
    mins_x60    = 32'(mins_est) * 32'd60;
    sec_rem     = s2_secs_r - mins_x60[30:0];
    sec_fix     = (sec_rem[6:0] >= 7'd60);
    s3_mins_nxt = mins_est + 26'(sec_fix);

    ms_est   = s2_pms_r[40:30];
    ms_x1000 = 21'(ms_est) * 21'd1000;
    ms_rem   = s2_usec_r - ms_x1000[19:0];
    ms_q     = ms_est + 11'(ms_rem[10:0] >= 11'd1000);

    s3_hms_nxt        = '0;
    s3_hms_nxt.second = sec_fix ? 6'(sec_rem[6:0] - 7'd60) : sec_rem[5:0];
    // out-of-range microseconds saturate
    s3_hms_nxt.milli  = (ms_q > 11'(MAX_MILLI)) ? MAX_MILLI : ms_q[9:0];
  end

  // ---------------------------------------------------------------- stage 4/5: minutes
  logic [51:0] s4_phr_nxt;
  logic [19:0] hr_est;
  logic [25:0] hr_x60;
  logic [25:0] min_rem;
  logic        min_fix;
  logic [19:0] s5_hours_nxt;
  hms_t        s5_hms_nxt;

  assign s4_phr_nxt = 52'(s3_mins_r) * 52'(RECIP_60);

  always_comb begin
    hr_est       = s4_phr_r[50:31];
    hr_x60       = 26'(hr_est) * 26'd60;
    min_rem      = s4_mins_r - hr_x60;
    min_fix      = (min_rem[6:0] >= 7'd60);
    // local offset joins before the day split
    s5_hours_nxt = hr_est + 20'(min_fix) + 20'(utc_off_r);
    s5_hms_nxt        = s4_hms_r;
    s5_hms_nxt.minute = min_fix ? 6'(min_rem[6:0] - 7'd60) : min_rem[5:0];
  end

  // ---------------------------------------------------------------- stage 6/7: hours
  logic [46:0] s6_pday_nxt;
  logic [14:0] day_est;
  logic [19:0] day_x24;
  logic [19:0] hr_rem;
  logic        hr_fix;
  logic [14:0] s7_days_nxt;
  hms_t        s7_hms_nxt;

  assign s6_pday_nxt = 47'(s5_hours_r) * 47'(RECIP_24);

  always_comb begin
    day_est     = s6_pday_r[45:31];
    day_x24     = 20'(day_est) * 20'd24;
    hr_rem      = s6_hours_r - day_x24;
    hr_fix      = (hr_rem[5:0] >= 6'd24);
    s7_days_nxt = day_est + 15'(hr_fix);
    s7_hms_nxt      = s6_hms_r;
    s7_hms_nxt.hour = hr_fix ? 5'(hr_rem[5:0] - 6'd24) : hr_rem[4:0];
  end

  // ---------------------------------------------------------------- stage 8/9: year estimate
  logic [38:0] s8_pyr_nxt;
  logic [6:0]  e_est;
  logic [24:0] days_x400;
  logic [24:0] e_x_cycle;
  logic [24:0] yr_rem;
  logic [6:0]  s9_e_nxt;

  assign s8_pyr_nxt = 39'(s7_days_r) * 39'(RECIP_YEAR);

  // exact floor(days * 400 / 146097)
  always_comb begin
    e_est     = s8_pyr_r[38:32];
    days_x400 = 25'(s8_days_r) * 25'd400;
    e_x_cycle = 25'(e_est) * CYCLE_DAYS;
    yr_rem    = days_x400 - e_x_cycle;
    s9_e_nxt  = e_est + 7'(yr_rem >= CYCLE_DAYS);
  end

  // ---------------------------------------------------------------- stage 10: year correction
  logic [15:0] dby_a;
  logic [15:0] dby_b;
  logic        yr_c1;
  logic        yr_c2;
  logic [6:0]  s10_k_nxt;

  // start one below the estimate, then step up (at most twice) while next Jan 1 is not past days
  always_comb begin
    dby_a     = DBY_TAB[s9_e_r];
    dby_b     = DBY_TAB[s9_e_r + 7'd1];
    yr_c1     = (dby_a <= 16'(s9_days_r));
    yr_c2     = yr_c1 && (dby_b <= 16'(s9_days_r));
    s10_k_nxt = s9_e_r - 7'd1 + 7'(yr_c1) + 7'(yr_c2);
  end

  // ---------------------------------------------------------------- stage 11: day of year, month estimate
  logic [15:0] yday_full;
  logic [8:0]  s11_yday_nxt;
  logic [17:0] q_prod;

  always_comb begin
    yday_full    = 16'(s10_days_r) - DBY_TAB[s10_k_r];
    s11_yday_nxt = yday_full[8:0];
    q_prod       = 18'(s11_yday_nxt) * 18'(RECIP_30);
  end

  // ---------------------------------------------------------------- stage 12: month and day
  logic [3:0] m0;
  logic [3:0] m1;
  logic [3:0] m2;
  logic       mo_c1;
  logic       mo_c2;
  logic [8:0] day_full;

  always_comb begin
    m0 = (s11_q_r == 4'd0) ? 4'd0 : s11_q_r - 4'd1;
    if (m0 > MONTH_DEC) begin
      m0 = MONTH_DEC;
    end
    mo_c1    = (m0 < MONTH_DEC) && (cum_days(m0 + 4'd1, s11_leap_r) <= s11_yday_r);
    m1       = m0 + 4'(mo_c1);
    mo_c2    = (m1 < MONTH_DEC) && (cum_days(m1 + 4'd1, s11_leap_r) <= s11_yday_r);
    m2       = m1 + 4'(mo_c2);
    day_full = s11_yday_r - cum_days(m2, s11_leap_r) + 9'd1;
  end

  // ---------------------------------------------------------------- payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_secs_r   <= in_tdata[SECS_W-1:0];
      s1_usec_r   <= in_tdata[SECS_W+USEC_W-1:SECS_W];

      s2_secs_r   <= s1_secs_r;
      s2_usec_r   <= s1_usec_r;
      s2_pmin_r   <= s2_pmin_nxt;
      s2_pms_r    <= s2_pms_nxt;

      s3_mins_r   <= s3_mins_nxt;
      s3_hms_r    <= s3_hms_nxt;

      s4_mins_r   <= s3_mins_r;
      s4_phr_r    <= s4_phr_nxt;
      s4_hms_r    <= s3_hms_r;

      s5_hours_r  <= s5_hours_nxt;
      s5_hms_r    <= s5_hms_nxt;

      s6_hours_r  <= s5_hours_r;
      s6_pday_r   <= s6_pday_nxt;
      s6_hms_r    <= s5_hms_r;

      s7_days_r   <= s7_days_nxt;
      s7_hms_r    <= s7_hms_nxt;

      s8_days_r   <= s7_days_r;
      s8_pyr_r    <= s8_pyr_nxt;
      s8_hms_r    <= s7_hms_r;

      s9_days_r   <= s8_days_r;
      s9_e_r      <= s9_e_nxt;
      s9_hms_r    <= s8_hms_r;

      s10_days_r  <= s9_days_r;
      s10_k_r     <= s10_k_nxt;
      s10_hms_r   <= s9_hms_r;

      s11_year_r  <= EPOCH_YEAR + 11'(s10_k_r);
      s11_yday_r  <= s11_yday_nxt;
      s11_q_r     <= q_prod[17:14];
      s11_leap_r  <= LEAP_TAB[s10_k_r];
      s11_hms_r   <= s10_hms_r;

      out_year_r  <= s11_year_r;
      out_month_r <= m2 + 4'd1;
      out_day_r   <= day_full[4:0];
      out_hms_r   <= s11_hms_r;
    end
  end

  assign out_tdata = {1'b0, out_hms_r.milli, out_hms_r.second, out_hms_r.minute,
                      out_hms_r.hour, out_day_r, out_month_r, out_year_r};

  // ---------------------------------------------------------------- assertions
  `E2C_ASSERT_ALWAYS(a_reset_flush, !rst_n |=> (vld_r == '0), "pipe not empty after reset")
  `E2C_ASSERT(a_item_count, (!in_xfer && !out_xfer) |=> $stable($countones(vld_r)),
    "item lost or duplicated in pipe")
  `E2C_ASSERT(a_fields_range, out_tvalid |-> (out_month_r >= 4'd1 && out_month_r <= 4'd12
    && out_day_r >= 5'd1 && out_hms_r.hour <= 5'd23 && out_hms_r.minute <= 6'd59
    && out_hms_r.second <= 6'd59 && out_hms_r.milli <= MAX_MILLI), "result field out of range")

endmodule

`default_nettype wire

// ===== test/epoch_to_calendar_time_top_tb.sv =====
// Testbench for epoch_to_calendar_time_top: streams Unix timestamps through the converter
// and checks each civil date/time result against a behavioral predictor in a scoreboard.
// Depends on e2c_pkg for port widths and the register map.
`timescale 1ns / 1ps

module epoch_to_calendar_time_top_tb;
  import e2c_pkg::*;

  // Result fields as packed on out_tdata, highest field first
  typedef struct packed {
    logic [9:0]  milli;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [10:0] year;
  } civil_time_t;

  localparam logic [CFG_AW-1:0] OFFSET_ADDR = CFG_AW'(4 * CFG_IDX_UTC_OFFSET);
  localparam int unsigned SECS_MAX = 32'h7FFF_FFFF;
  localparam int unsigned USEC_MAX = 32'h000F_FFFF;

  // Scoreboard: civil time predictor plus the queue of dates still due
  class calendar_scoreboard;
    logic [3:0]  offset_hrs;
    civil_time_t due_q[$];
    int          errors;
    int          month_norm[13];
    int          month_leap[13];

    function new();
      offset_hrs = UTC_OFFSET_RST;
      errors     = 0;
      month_norm = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      month_leap = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};
    endfunction

    function void set_offset(logic [3:0] hrs);
      offset_hrs = hrs;
    endfunction

    function bit leap_year(int yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    // days from 1970-01-01 to January 1 of yr
    function int jan1_day(int yr);
      int p;
      p = yr - 1;
      return (yr - 1970) * 365 + p / 4 - p / 100 + p / 400 - 477;
    endfunction

    function int month_start(int mon, int yr);
      if (mon < 0) mon = 0;
      if (mon > 12) mon = 12;
      return leap_year(yr) ? month_leap[mon] : month_norm[mon];
    endfunction

    function civil_time_t to_civil(logic [30:0] secs, logic [19:0] usec);
      civil_time_t r;
      longint mins;
      longint hours;
      int     days;
      int     yr;
      int     mon;
      int     yday;
      int     ms;
      ms = usec / 1000;
      if (ms > 999) ms = 999;            // out-of-range microseconds saturate
      mins  = longint'(secs) / 60;
      hours = mins / 60 + offset_hrs;
      days  = int'(hours / 24);
      // year estimate, then at most two corrections
      yr = 1969 + int'((longint'(days) * 400) / 146097);
      repeat (2) if (jan1_day(yr + 1) <= days) yr++;
      yday = days - jan1_day(yr);
      // month estimate from day of year, then at most two corrections
      mon = yday / 30;
      mon = (mon > 0) ? mon - 1 : 0;
      if (mon > 11) mon = 11;
      repeat (2) if (mon < 11 && month_start(mon + 1, yr) <= yday) mon++;
      yday -= month_start(mon, yr);
      r.year   = 11'(yr);
      r.month  = 4'(mon + 1);
      r.day    = 5'(yday + 1);
      r.hour   = 5'(hours % 24);
      r.minute = 6'(mins % 60);
      r.second = 6'(longint'(secs) % 60);
      r.milli  = 10'(ms);
      return r;
    endfunction

    function void note_stamp(logic [30:0] secs, logic [19:0] usec);
      due_q.push_back(to_civil(secs, usec));
    endfunction

    function void cmp_field(string what, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [OUT_DW-1:0] word);
      civil_time_t got;
      civil_time_t want;
      got = civil_time_t'(word[46:0]);
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result with none due, expected nothing, actual %h", $time, word);
        return;
      end
      want = due_q.pop_front();
      cmp_field("year", want.year, got.year);
      cmp_field("month", want.month, got.month);
      cmp_field("day", want.day, got.day);
      cmp_field("hour", want.hour, got.hour);
      cmp_field("minute", want.minute, got.minute);
      cmp_field("second", want.second, got.second);
      cmp_field("milli", want.milli, got.milli);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;      // epoch_seconds[30:0], micro_seconds[50:31], 0
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;         // year, month, day, hour, minute, second, milli, 0
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  calendar_scoreboard sb = new();

  bit in_calm = 1'b0;    // no input gaps while set
  bit out_calm = 1'b0;   // no output stalls while set
  int hold_left = 0;

  epoch_to_calendar_time_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer, then drop out_tready for a random stall unless out_calm is set
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        hold_left = out_calm ? 0 : $urandom_range(0, 12);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One timestamp transfer after a random gap unless in_calm is set; tvalid stays high afterwards
  task automatic send_stamp(input logic [30:0] secs, input logic [19:0] usec);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, usec, secs};
    do @(posedge clk); while (!in_tready);
    sb.note_stamp(secs, usec);
  endtask

  // Drain the pipe, then write the offset register with an APB setup phase and access phase
  task automatic write_offset(input logic [3:0] hrs);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= OFFSET_ADDR;
    cfg_pwdata  <= CFG_DW'(hrs);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_offset(hrs);
  endtask

  task automatic random_stamp();
    longint secs;
    int     pick;
    int     usec;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      secs = $urandom & SECS_MAX;
    end else if (pick < 85) begin
      // around a local midnight
      secs = longint'($urandom_range(1, 24855)) * 86400 - longint'(sb.offset_hrs) * 3600
             + int'($urandom_range(0, 6)) - 3;
    end else begin
      secs = longint'(SECS_MAX) - $urandom_range(0, 100000000);
    end
    if (secs < 0) secs = 0;
    if (secs > SECS_MAX) secs = SECS_MAX;
    pick = $urandom_range(0, 99);
    if (pick < 60) usec = $urandom_range(0, 999999);
    else if (pick < 85) usec = $urandom & USEC_MAX;
    else usec = $urandom_range(998000, USEC_MAX);
    send_stamp(31'(secs), 20'(usec));
  endtask

  initial begin
    int unsigned dir_secs[20];
    int unsigned dir_usec[20];
    logic [3:0]  hrs;
    dir_secs = '{0, SECS_MAX, 0, 59, 951782400, 951868799, 946684799, 946655999,
                 1078099200, 1104537599, 1000000, 1000, 31535999, 1234567890,
                 1706745600, 1709164800, 1709251199, 2145916799, 2145916800, 68169599};
    dir_usec = '{0, 999999, USEC_MAX, 999, 999000, 1000000, 999999, 0,
                 1, 500000, 999000, 1000, 999999, 123456,
                 0, 1048000, 999, 999999, 0, 524288};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 7; ph++) begin
      // phase 0 runs on the reset offset; then 0, 15, 14 and random values
      if (ph > 0) begin
        case (ph)
          1:       hrs = 4'd0;
          2:       hrs = 4'd15;
          3:       hrs = 4'd14;
          default: hrs = 4'($urandom_range(0, 15));
        endcase
        write_offset(hrs);
      end
      in_calm  = (ph % 2) == 1;
      out_calm = 1'b0;
      if (ph == 0) begin
        foreach (dir_secs[i]) send_stamp(31'(dir_secs[i]), 20'(dir_usec[i]));
      end else begin
        send_stamp(31'd0, 20'd0);
        send_stamp(31'(SECS_MAX), 20'(USEC_MAX));
        send_stamp(31'd2145916799, 20'd999999);
      end
      for (int n = 0; n < 290; n++) begin
        // change idling style every few dozen transfers
        if (n % 48 == 0) begin
          in_calm  = ($urandom_range(0, 3) == 0);
          out_calm = ($urandom_range(0, 3) == 0);
        end
        random_stamp();
      end
    end
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/e2c_pkg.sv
rtl/core/epoch_to_calendar_time_top.sv
test/epoch_to_calendar_time_top_tb.sv
